// ----- hw/rtl/firl_pkg.sv -----
// shared types for the fir lattice filter
package firl_pkg;

    typedef logic signed [31:0] stage_t;
    typedef logic signed [15:0] coef_t;

    typedef struct packed {
        stage_t f;
        stage_t g;
    } lat_res_t;

    // request codes
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_COEF   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

endpackage

// ----- hw/rtl/fir_lattice_filter.sv -----
// fir lattice filter top level: sequencer, coefficient and stage delay memories
// a sample transaction walks every stage, a multiply state then an add state per stage, and raises its result
// when the final add advances; a new sample is accepted only in idle, once the previous sample has finished
// a result not yet taken holds the final stage until out_ready
// coefficient and clear transactions complete on acceptance and give no result
// reset (rst_n low, asynchronous) zeroes all coefficients and stage delays
module fir_lattice_filter #(
    parameter int TAPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] sample_in,
    input  logic [4:0]  coef_index,
    input  logic signed [15:0] coef_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] filtered
);
    import firl_pkg::*;

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = (AW > 5) ? AW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [TAPS-1:0] dvalid_reg;
    logic [TAPS-1:0] cvalid_reg;
    logic          out_valid_reg;
    logic [15:0]   filtered_reg;
    stage_t        d0_reg;

    stage_t        f_reg, gp_reg, gc_reg;
    logic [15:0]   x_reg;
    stage_t        rd_g_reg;
    coef_t         rd_k_reg;
    logic          rd_gv_reg, rd_kv_reg;

    stage_t        dmem [TAPS];
    coef_t         cmem [TAPS];

    logic          accept, is_sample, is_coef, is_clear, coef_ok;
    logic          last, advance, rd_en;
    logic [AW-1:0] raddr, idx_inc;
    logic [CW-1:0] ci_m1;
    coef_t         k_op;
    lat_res_t      res;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_sample = accept && (req_type == REQ_SAMPLE);
    assign is_coef   = accept && (req_type == REQ_COEF);
    assign is_clear  = accept && (req_type == REQ_CLEAR);
    assign coef_ok   = (coef_index != 5'd0) && (32'(coef_index) <= 32'(TAPS));
    assign ci_m1     = CW'(coef_index) - CW'(1);

    assign last      = (idx_reg == AW'(TAPS - 1));
    assign advance   = (state_reg == S_ADD) && (!last || !out_valid_reg || out_ready);
    assign idx_inc   = last ? '0 : idx_reg + AW'(1);
    assign rd_en     = is_sample || (state_reg == S_MUL);
    assign raddr     = is_sample ? '0 : idx_inc;
    assign k_op      = rd_kv_reg ? rd_k_reg : '0;

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    firl_mac u_mac (
        .clk    (clk),
        .mul_en (state_reg == S_MUL),
        .k      (k_op),
        .f_in   (f_reg),
        .gp_in  (gp_reg),
        .res    (res)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (is_sample)
                begin
                    state_next = S_MUL;
                    idx_next   = '0;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (advance)
                begin
                    state_next = last ? S_IDLE : S_MUL;
                    idx_next   = idx_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            dvalid_reg    <= '0;
            cvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            d0_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (is_clear)
            begin
                dvalid_reg <= '0;
                d0_reg     <= '0;
            end
            else if (advance)
            begin
                dvalid_reg[idx_reg] <= 1'b1;
            end
            if (is_sample)
                d0_reg <= 32'(sample_in);
            if (is_coef && coef_ok)
                cvalid_reg[ci_m1[AW-1:0]] <= 1'b1;
            if (advance && last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // memories and datapath registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_g_reg  <= dmem[raddr];
            rd_k_reg  <= cmem[raddr];
            rd_gv_reg <= dvalid_reg[raddr];
            rd_kv_reg <= cvalid_reg[raddr];
        end
        if (is_coef && coef_ok)
            cmem[ci_m1[AW-1:0]] <= coef_value;
        if (advance)
            dmem[idx_reg] <= res.g;
    end

    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            f_reg  <= 32'(sample_in);
            gp_reg <= d0_reg;
            x_reg  <= sample_in;
        end
        else if (advance)
        begin
            f_reg  <= res.f;
            gp_reg <= gc_reg;
        end
        if (state_reg == S_MUL)
            gc_reg <= rd_gv_reg ? rd_g_reg : '0;
        if (advance && last)
            filtered_reg <= res.f[15:0] - x_reg;
    end

`ifndef NO_ASSERTIONS
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        is_sample |=> state_reg == S_MUL && idx_reg == '0)
        else $error("sample transaction did not start the stage walk");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ADD) && $past(last))
        else $error("result raised outside the final stage");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> idx_reg <= AW'(TAPS - 1))
        else $error("stage index out of range");

    a_clear_delays: assert property (@(posedge clk) disable iff (!rst_n)
        is_clear |=> dvalid_reg == '0 && d0_reg == '0)
        else $error("clear transaction left stage delays");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(filtered_reg))
        else $error("waiting result lost");
`endif

endmodule

// ----- hw/rtl/firl_mac.sv -----
// shared lattice butterfly: two registered products, then truncate, add and saturate
module firl_mac (
    input  logic              clk,
    input  logic              mul_en,
    input  firl_pkg::coef_t   k,
    input  firl_pkg::stage_t  f_in,
    input  firl_pkg::stage_t  gp_in,
    output firl_pkg::lat_res_t res
);
    import firl_pkg::*;

    logic signed [47:0] pf_reg;
    logic signed [47:0] pg_reg;
    logic signed [33:0] qf;
    logic signed [33:0] qg;

    // product over 2^14, rounded toward zero
    function automatic logic signed [33:0] qdiv(input logic signed [47:0] p);
        logic signed [47:0] b;
        b = p + (p[47] ? 48'sd16383 : 48'sd0);
        return b[47:14];
    endfunction

    function automatic stage_t sat32(input logic signed [34:0] v);
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111)
            return v[31:0];
        else if (v[34])
            return 32'sh8000_0000;
        else
            return 32'sh7fff_ffff;
    endfunction

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            pf_reg <= 48'(k) * 48'(f_in);
            pg_reg <= 48'(k) * 48'(gp_in);
        end
    end

    always_comb
    begin
        qf    = qdiv(pf_reg);
        qg    = qdiv(pg_reg);
        res.g = sat32(35'(qf) + 35'(gp_in));
        res.f = sat32(35'(f_in) + 35'(qg));
    end

endmodule
